### src/jsu_pkg.sv
// Package for the JSON string unescaper: scan modes, result codes, the result
// record, and the hex, UTF-8 encode and UTF-8 check helper functions.
// Depends on nothing.
package jsu_pkg;

	localparam int unsigned LENGTH_LIMIT = 262144;
	localparam int unsigned LEN_W = 19;
	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned MAX_RESULTS = 4;
	localparam logic [LEN_W-1:0] MAX_BYTES_RESET = LEN_W'(4096);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		M_WAIT,
		M_BODY,
		M_ESC,
		M_HEX,
		M_PAIR_BS,
		M_PAIR_U,
		M_LOW_HEX
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_DONE,
		KIND_REJECT
	} kind_t;

	typedef enum logic [3:0] {
		CAUSE_NONE,
		CAUSE_NO_QUOTE,
		CAUSE_CONTROL,
		CAUSE_BAD_ESCAPE,
		CAUSE_BAD_HEX,
		CAUSE_BAD_SURROGATE,
		CAUSE_TOO_LONG,
		CAUSE_BAD_UTF8,
		CAUSE_SOURCE_ENDED
	} cause_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		cause_t cause;
		logic [LEN_W-1:0] len;
		logic last;
	} res_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0] n;
		logic [3:0][7:0] bytes;
	} enc_t;

	typedef struct packed {
		logic [1:0] pend;
		logic [20:0] part;
		logic [1:0] cls;
		logic failed;
	} u8_t;

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.val = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t r;
		r.bytes = '0;
		if (cp <= 21'h7f) begin
			r.n = 3'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp <= 21'h7ff) begin
			r.n = 3'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hffff) begin
			r.n = 3'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.n = 3'd4;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

	function automatic u8_t utf8_feed(input u8_t s, input logic [7:0] b);
		u8_t r;
		logic [20:0] lo;
		r = s;
		lo = 21'h10000;
		if (!s.failed) begin
			if (s.pend == 2'd0) begin
				if (b[7]) begin
					if (b[7:5] == 3'b110) begin
						r.part = {16'd0, b[4:0]};
						r.pend = 2'd1;
						r.cls = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						r.part = {17'd0, b[3:0]};
						r.pend = 2'd2;
						r.cls = 2'd2;
					end else if (b[7:3] == 5'b11110) begin
						r.part = {18'd0, b[2:0]};
						r.pend = 2'd3;
						r.cls = 2'd3;
					end else begin
						r.failed = 1'b1;
					end
				end
			end else if (b[7:6] != 2'b10) begin
				r.failed = 1'b1;
			end else begin
				r.part = {s.part[14:0], b[5:0]};
				r.pend = s.pend - 2'd1;
				if (s.pend == 2'd1) begin
					if (s.cls == 2'd1) begin
						lo = 21'h80;
					end else if (s.cls == 2'd2) begin
						lo = 21'h800;
					end
					if (r.part < lo || r.part > 21'h10ffff ||
							(r.part >= 21'hd800 && r.part <= 21'hdfff)) begin
						r.failed = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

endpackage

### src/json_string_unescaper.sv
// JSON string unescaper top level: byte-wide decoder with a small result queue.
// Depends on jsu_pkg.
//
// Usage: the source text enters one byte per request on the input channel
// (data_byte, source_ends), starting at the opening quote of a string. Each
// request is decoded in the cycle it is accepted and produces zero to four
// results, which are pushed into an eight-entry queue. The output channel
// delivers one result per cycle while out_stall is low, from the head of
// that queue: a decoded byte, a finish with the decoded length, or a
// rejection with its cause. The last result caused by one request carries
// last_of_run. The input takes one request per cycle as long as the queue
// has room for four results; a request that expands into several bytes
// fills as many entries, so the sustained rate is one result per cycle.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than four entries are free. After reset the queue is empty, the decoder
// waits for an opening quote and max_bytes holds 4096. max_bytes is written
// through cfg_write_en and cfg_write_data; the user must do so only while
// the block is idle, which the block itself does not enforce.
module json_string_unescaper (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [jsu_pkg::LEN_W-1:0]  cfg_write_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       source_ends,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 result_kind,
	output logic [7:0]                 out_byte,
	output logic [3:0]                 error_cause,
	output logic [jsu_pkg::LEN_W-1:0]  decoded_length,
	output logic                       last_of_run
);
	import jsu_pkg::*;

	logic [LEN_W-1:0] max_bytes_q;
	mode_t mode_q, mode_d;
	logic [11:0] acc_q, acc_d;
	logic [1:0] dig_q, dig_d;
	logic [9:0] ph_q, ph_d;
	logic [LEN_W-1:0] len_q, len_d;
	u8_t u8_q, u8_d;

	res_t queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic accept, pop;
	logic [LEN_W-1:0] limit;
	hex_t hv;
	logic [15:0] unit;
	logic [20:0] pair_cp;
	logic rej, fin, em;
	cause_t cause;
	enc_t enc;
	logic [LEN_W:0] len_sum;
	res_t res_w [MAX_RESULTS];
	logic [2:0] res_n;
	res_t head;

	assign accept = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign limit = (max_bytes_q < LEN_W'(LENGTH_LIMIT)) ? max_bytes_q : LEN_W'(LENGTH_LIMIT);
	assign hv = hex_val(data_byte);
	assign unit = {acc_q, hv.val};
	assign pair_cp = 21'h10000 + {1'b0, ph_q, unit[9:0]};
	assign len_sum = {1'b0, len_q} + (LEN_W + 1)'(enc.n);

	always_comb begin
		mode_d = mode_q;
		acc_d = acc_q;
		dig_d = dig_q;
		ph_d = ph_q;
		len_d = len_q;
		u8_d = u8_q;
		rej = 1'b0;
		fin = 1'b0;
		em = 1'b0;
		cause = CAUSE_NONE;
		enc.n = 3'd1;
		enc.bytes = '0;
		enc.bytes[0] = data_byte;
		if (mode_q == M_WAIT) begin
			if (!source_ends && data_byte == CH_QUOTE) begin
				mode_d = M_BODY;
				acc_d = '0;
				dig_d = '0;
				ph_d = '0;
				len_d = '0;
				u8_d = '0;
			end else begin
				rej = 1'b1;
				cause = CAUSE_NO_QUOTE;
			end
		end else if (source_ends) begin
			rej = 1'b1;
			cause = CAUSE_SOURCE_ENDED;
		end else begin
			case (mode_q)
				M_BODY: begin
					if (data_byte == CH_QUOTE) begin
						if (len_q > limit) begin
							rej = 1'b1;
							cause = CAUSE_TOO_LONG;
						end else if (u8_q.failed || u8_q.pend != 2'd0) begin
							rej = 1'b1;
							cause = CAUSE_BAD_UTF8;
						end else begin
							fin = 1'b1;
						end
					end else if (data_byte < CH_SPACE) begin
						rej = 1'b1;
						cause = CAUSE_CONTROL;
					end else if (data_byte == CH_BSLASH) begin
						mode_d = M_ESC;
					end else begin
						em = 1'b1;
					end
				end
				M_ESC: begin
					em = 1'b1;
					case (data_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: enc.bytes[0] = data_byte;
						CH_B: enc.bytes[0] = 8'h08;
						CH_F: enc.bytes[0] = 8'h0c;
						CH_N: enc.bytes[0] = 8'h0a;
						CH_R: enc.bytes[0] = 8'h0d;
						CH_T: enc.bytes[0] = 8'h09;
						CH_U: begin
							em = 1'b0;
							acc_d = '0;
							dig_d = '0;
							mode_d = M_HEX;
						end
						default: begin
							em = 1'b0;
							rej = 1'b1;
							cause = CAUSE_BAD_ESCAPE;
						end
					endcase
				end
				M_HEX, M_LOW_HEX: begin
					if (!hv.ok) begin
						rej = 1'b1;
						cause = CAUSE_BAD_HEX;
					end else if (dig_q != 2'd3) begin
						acc_d = {acc_q[7:0], hv.val};
						dig_d = dig_q + 2'd1;
					end else begin
						acc_d = '0;
						dig_d = '0;
						if (mode_q == M_HEX) begin
							if (unit >= 16'hd800 && unit <= 16'hdbff) begin
								ph_d = unit[9:0];
								mode_d = M_PAIR_BS;
							end else if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
								rej = 1'b1;
								cause = CAUSE_BAD_SURROGATE;
							end else begin
								em = 1'b1;
								enc = utf8_encode({5'd0, unit});
							end
						end else if (unit < 16'hdc00 || unit > 16'hdfff) begin
							rej = 1'b1;
							cause = CAUSE_BAD_SURROGATE;
						end else begin
							em = 1'b1;
							enc = utf8_encode(pair_cp);
						end
					end
				end
				M_PAIR_BS: begin
					if (data_byte == CH_BSLASH) begin
						mode_d = M_PAIR_U;
					end else begin
						rej = 1'b1;
						cause = CAUSE_BAD_SURROGATE;
					end
				end
				M_PAIR_U: begin
					if (data_byte == CH_U) begin
						acc_d = '0;
						dig_d = '0;
						mode_d = M_LOW_HEX;
					end else begin
						rej = 1'b1;
						cause = CAUSE_BAD_SURROGATE;
					end
				end
				default: mode_d = M_WAIT;
			endcase
		end
		if (em) begin
			if (len_sum > {1'b0, limit}) begin
				em = 1'b0;
				rej = 1'b1;
				cause = CAUSE_TOO_LONG;
			end else begin
				len_d = len_sum[LEN_W-1:0];
				mode_d = M_BODY;
				for (int k = 0; k < MAX_RESULTS; k++) begin
					if (3'(k) < enc.n) begin
						u8_d = utf8_feed(u8_d, enc.bytes[k]);
					end
				end
			end
		end
		if (rej || fin) begin
			mode_d = M_WAIT;
		end
	end

	always_comb begin
		res_n = 3'd0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			res_w[k].kind = KIND_BYTE;
			res_w[k].data = enc.bytes[k];
			res_w[k].cause = CAUSE_NONE;
			res_w[k].len = '0;
			res_w[k].last = (3'(k) == enc.n - 3'd1);
		end
		if (rej) begin
			res_n = 3'd1;
			res_w[0].kind = KIND_REJECT;
			res_w[0].data = '0;
			res_w[0].cause = cause;
			res_w[0].last = 1'b1;
		end else if (fin) begin
			res_n = 3'd1;
			res_w[0].kind = KIND_DONE;
			res_w[0].data = '0;
			res_w[0].len = len_q;
			res_w[0].last = 1'b1;
		end else if (em) begin
			res_n = enc.n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RESET;
		end else if (cfg_write_en) begin
			max_bytes_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_WAIT;
			acc_q <= '0;
			dig_q <= '0;
			ph_q <= '0;
			len_q <= '0;
			u8_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q <= acc_d;
			dig_q <= dig_d;
			ph_q <= ph_d;
			len_q <= len_d;
			u8_q <= u8_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (accept ? PTR_W'(res_n) : PTR_W'(0));
			rd_ptr_q <= rd_ptr_q + (pop ? PTR_W'(1) : PTR_W'(0));
			cnt_q <= cnt_q + (accept ? CNT_W'(res_n) : CNT_W'(0)) -
				(pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (3'(k) < res_n) begin
					queue_q[wr_ptr_q + PTR_W'(k)] <= res_w[k];
				end
			end
		end
	end

	assign head = queue_q[rd_ptr_q];
	assign in_stall = (cnt_q > CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
	assign out_valid = (cnt_q != '0);
	assign result_kind = head.kind;
	assign out_byte = head.data;
	assign error_cause = head.cause;
	assign decoded_length = head.len;
	assign last_of_run = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("result queue count exceeds its depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_n != 3'd0) |=> out_valid)
		else $error("accepted request with results left the queue empty");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LENGTH_LIMIT))
		else $error("decoded length grew beyond the hard limit");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_kind != 2'd3))
		else $error("illegal result kind at the queue head");

endmodule

### tb/json_string_unescaper_test.sv
// Self-checking testbench for json_string_unescaper: directed and random JSON string bytes,
// random input gaps and output stalls, results compared with a behavioral decoder of its own.
// Depends on jsu_pkg and json_string_unescaper.
module json_string_unescaper_test;
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic e;
	} src_item_t;

	typedef struct packed {
		logic [7:0] b;
		logic e;
		logic typed;
		kind_t k;
		cause_t c;
	} drill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [LEN_W-1:0] cfg_write_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = 8'h00;
	logic source_ends = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] result_kind;
	logic [7:0] out_byte;
	logic [3:0] error_cause;
	logic [LEN_W-1:0] decoded_length;
	logic last_of_run;

	res_t step_out[$];
	res_t pending_results[$];
	src_item_t script[$];
	drill_t drill [28];
	logic [LEN_W-1:0] limits [6];

	mode_t scan;
	logic [15:0] hex_word;
	int unsigned hex_count;
	logic [9:0] high_bits;
	int unsigned decoded_count;
	int unsigned utf8_left;
	logic [20:0] utf8_value;
	logic [20:0] utf8_floor;
	bit utf8_broken;
	logic [LEN_W-1:0] max_bytes_reg;

	int mismatches = 0;
	bit calm = 1'b0;
	int stall_run = 0;

	json_string_unescaper DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.source_ends(source_ends),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.out_byte(out_byte),
		.error_cause(error_cause),
		.decoded_length(decoded_length),
		.last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	function automatic int unsigned byte_limit();
		return (max_bytes_reg < LENGTH_LIMIT) ? int'(max_bytes_reg) : LENGTH_LIMIT;
	endfunction

	function automatic void push_result(kind_t k, logic [7:0] d, cause_t c, logic [LEN_W-1:0] n);
		res_t r;
		r.kind = k;
		r.data = d;
		r.cause = c;
		r.len = n;
		r.last = 1'b0;
		step_out.insert(step_out.size(), r);
	endfunction

	function automatic void reject(cause_t c);
		push_result(KIND_REJECT, 8'h00, c, '0);
		scan = M_WAIT;
	endfunction

	function automatic void open_string();
		scan = M_BODY;
		hex_word = '0;
		hex_count = 0;
		high_bits = '0;
		decoded_count = 0;
		utf8_left = 0;
		utf8_value = '0;
		utf8_floor = '0;
		utf8_broken = 1'b0;
	endfunction

	function automatic int hex_value(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic logic [31:0] utf8_of(logic [20:0] cp, output int unsigned n);
		logic [7:0] b0, b1, b2, b3;
		b0 = 8'h00;
		b1 = 8'h00;
		b2 = 8'h00;
		b3 = 8'h00;
		if (cp < 21'h80) begin
			b0 = cp[7:0];
			n = 1;
		end else if (cp < 21'h800) begin
			b0 = 8'hc0 | 8'(cp >> 6);
			b1 = 8'h80 | 8'(cp & 21'h3f);
			n = 2;
		end else if (cp < 21'h10000) begin
			b0 = 8'he0 | 8'(cp >> 12);
			b1 = 8'h80 | 8'((cp >> 6) & 21'h3f);
			b2 = 8'h80 | 8'(cp & 21'h3f);
			n = 3;
		end else begin
			b0 = 8'hf0 | 8'((cp >> 18) & 21'h07);
			b1 = 8'h80 | 8'((cp >> 12) & 21'h3f);
			b2 = 8'h80 | 8'((cp >> 6) & 21'h3f);
			b3 = 8'h80 | 8'(cp & 21'h3f);
			n = 4;
		end
		return {b3, b2, b1, b0};
	endfunction

	function automatic void utf8_track(logic [7:0] b);
		if (utf8_broken) return;
		if (utf8_left == 0) begin
			if (b < 8'h80) return;
			if ((b & 8'he0) == 8'hc0) begin
				utf8_value = 21'(b & 8'h1f);
				utf8_left = 1;
				utf8_floor = 21'h80;
			end else if ((b & 8'hf0) == 8'he0) begin
				utf8_value = 21'(b & 8'h0f);
				utf8_left = 2;
				utf8_floor = 21'h800;
			end else if ((b & 8'hf8) == 8'hf0) begin
				utf8_value = 21'(b & 8'h07);
				utf8_left = 3;
				utf8_floor = 21'h10000;
			end else begin
				utf8_broken = 1'b1;
			end
			return;
		end
		if ((b & 8'hc0) != 8'h80) begin
			utf8_broken = 1'b1;
			return;
		end
		utf8_value = {utf8_value[14:0], b[5:0]};
		utf8_left--;
		if (utf8_left == 0 && (utf8_value < utf8_floor || utf8_value > 21'h10ffff ||
				(utf8_value >= 21'hd800 && utf8_value <= 21'hdfff)))
			utf8_broken = 1'b1;
	endfunction

	function automatic void emit_seq(logic [3:0][7:0] bytes, int unsigned n);
		if (decoded_count + n > byte_limit()) begin
			reject(CAUSE_TOO_LONG);
			return;
		end
		for (int i = 0; i < n; i++) begin
			utf8_track(bytes[i]);
			push_result(KIND_BYTE, bytes[i], CAUSE_NONE, '0);
		end
		decoded_count += n;
		scan = M_BODY;
	endfunction

	function automatic void emit_codepoint(logic [20:0] cp);
		int unsigned n;
		logic [31:0] enc;
		enc = utf8_of(cp, n);
		emit_seq(enc, n);
	endfunction

	function automatic void hex_digit_step(logic [7:0] c);
		int d;
		logic [15:0] unit_word;
		d = hex_value(c);
		if (d < 0) begin
			reject(CAUSE_BAD_HEX);
			return;
		end
		hex_word = {hex_word[11:0], 4'(d)};
		hex_count++;
		if (hex_count < 4) return;
		unit_word = hex_word;
		hex_word = '0;
		hex_count = 0;
		if (scan == M_HEX) begin
			if (unit_word >= 16'hd800 && unit_word <= 16'hdbff) begin
				high_bits = 10'(unit_word - 16'hd800);
				scan = M_PAIR_BS;
			end else if (unit_word >= 16'hdc00 && unit_word <= 16'hdfff) begin
				reject(CAUSE_BAD_SURROGATE);
			end else begin
				emit_codepoint({5'd0, unit_word});
			end
		end else if (unit_word < 16'hdc00 || unit_word > 16'hdfff) begin
			reject(CAUSE_BAD_SURROGATE);
		end else begin
			emit_codepoint(21'h10000 + {1'b0, high_bits, 10'd0} + 21'(unit_word - 16'hdc00));
		end
	endfunction

	// Advances the model by one source byte; queues its results or, if typed, the given one.
	function automatic void decode_step(logic [7:0] c, logic e, bit typed, kind_t k, cause_t cz);
		res_t fixed;
		step_out.delete();
		if (scan == M_WAIT) begin
			if (!e && c == CH_QUOTE) open_string();
			else reject(CAUSE_NO_QUOTE);
		end else if (e) begin
			reject(CAUSE_SOURCE_ENDED);
		end else begin
			case (scan)
				M_BODY: begin
					if (c == CH_QUOTE) begin
						if (decoded_count > byte_limit()) begin
							reject(CAUSE_TOO_LONG);
						end else if (utf8_broken || utf8_left != 0) begin
							reject(CAUSE_BAD_UTF8);
						end else begin
							push_result(KIND_DONE, 8'h00, CAUSE_NONE, LEN_W'(decoded_count));
							scan = M_WAIT;
						end
					end else if (c < CH_SPACE) begin
						reject(CAUSE_CONTROL);
					end else if (c == CH_BSLASH) begin
						scan = M_ESC;
					end else begin
						emit_seq({24'd0, c}, 1);
					end
				end
				M_ESC: begin
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: emit_seq({24'd0, c}, 1);
						CH_B: emit_seq(32'h08, 1);
						CH_F: emit_seq(32'h0c, 1);
						CH_N: emit_seq(32'h0a, 1);
						CH_R: emit_seq(32'h0d, 1);
						CH_T: emit_seq(32'h09, 1);
						CH_U: begin
							hex_word = '0;
							hex_count = 0;
							scan = M_HEX;
						end
						default: reject(CAUSE_BAD_ESCAPE);
					endcase
				end
				M_HEX, M_LOW_HEX: hex_digit_step(c);
				M_PAIR_BS: begin
					if (c == CH_BSLASH) scan = M_PAIR_U;
					else reject(CAUSE_BAD_SURROGATE);
				end
				M_PAIR_U: begin
					if (c == CH_U) begin
						hex_word = '0;
						hex_count = 0;
						scan = M_LOW_HEX;
					end else begin
						reject(CAUSE_BAD_SURROGATE);
					end
				end
				default: scan = M_WAIT;
			endcase
		end
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
		if (typed) begin
			fixed.kind = k;
			fixed.data = 8'h00;
			fixed.cause = cz;
			fixed.len = '0;
			fixed.last = 1'b1;
			pending_results.insert(pending_results.size(), fixed);
		end else begin
			foreach (step_out[i]) pending_results.insert(pending_results.size(), step_out[i]);
		end
	endfunction

	function automatic void add_byte(logic [7:0] b);
		script.insert(script.size(), {b, 1'b0});
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10) return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	function automatic void add_unicode(logic [15:0] v);
		add_byte(CH_BSLASH);
		add_byte(CH_U);
		add_byte(hex_char(v[15:12]));
		add_byte(hex_char(v[11:8]));
		add_byte(hex_char(v[7:4]));
		add_byte(hex_char(v[3:0]));
	endfunction

	function automatic logic [15:0] high_half();
		return 16'($urandom_range(16'hd800, 16'hdbff));
	endfunction

	function automatic void add_piece();
		logic [7:0] b;
		logic [15:0] v;
		logic [20:0] cp;
		logic [3:0][7:0] enc;
		int unsigned n;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				b = 8'($urandom_range(8'h20, 8'h7e));
				if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h7e;
				add_byte(b);
			end
			3: begin
				case ($urandom_range(0, 2))
					0: cp = 21'($urandom_range(21'h80, 21'h7ff));
					1: begin
						cp = 21'($urandom_range(21'h800, 21'hffff));
						if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h4000;
					end
					default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
				endcase
				enc = utf8_of(cp, n);
				for (int i = 0; i < n; i++) add_byte(enc[i]);
			end
			4: add_byte(8'($urandom_range(8'h80, 8'hff)));
			5, 6: begin
				add_byte(CH_BSLASH);
				case ($urandom_range(0, 7))
					0: add_byte(CH_QUOTE);
					1: add_byte(CH_BSLASH);
					2: add_byte(CH_SLASH);
					3: add_byte(CH_B);
					4: add_byte(CH_F);
					5: add_byte(CH_N);
					6: add_byte(CH_R);
					default: add_byte(CH_T);
				endcase
			end
			7: begin
				v = $urandom_range(0, 2) == 0 ? 16'($urandom_range(0, 16'h7ff)) : 16'($urandom);
				if (v >= 16'hd800 && v <= 16'hdfff) v = v ^ 16'h4000;
				add_unicode(v);
			end
			8: begin
				add_unicode(high_half());
				add_unicode(16'($urandom_range(16'hdc00, 16'hdfff)));
			end
			default: add_unicode(16'($urandom));
		endcase
	endfunction

	// Adds a sequence that always makes the decoder reject the string.
	function automatic void add_broken();
		logic [7:0] b;
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: begin
				do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH ||
					b == CH_B || b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
				add_byte(CH_BSLASH);
				add_byte(b);
			end
			1: begin
				do b = 8'($urandom); while (hex_value(b) >= 0);
				add_byte(CH_BSLASH);
				add_byte(CH_U);
				repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
				add_byte(b);
			end
			2: add_unicode(16'($urandom_range(16'hdc00, 16'hdfff)));
			3: begin
				add_unicode(high_half());
				do b = 8'($urandom); while (b == CH_BSLASH);
				add_byte(b);
			end
			4: begin
				add_unicode(high_half());
				add_byte(CH_BSLASH);
				do b = 8'($urandom); while (b == CH_U);
				add_byte(b);
			end
			5: begin
				add_unicode(high_half());
				do v = 16'($urandom); while (v >= 16'hdc00 && v <= 16'hdfff);
				add_unicode(v);
			end
			6: add_byte(8'($urandom_range(0, 8'h1f)));
			default: script.insert(script.size(), {8'($urandom), 1'b1});
		endcase
	endfunction

	function automatic void compose_string();
		int pieces;
		int broken_at;
		logic [7:0] b;
		pieces = $urandom_range(0, 6);
		broken_at = $urandom_range(0, 5) == 0 ? $urandom_range(0, pieces) : -1;
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				script.insert(script.size(), {8'($urandom), 1'b1});
			end else begin
				do b = 8'($urandom); while (b == CH_QUOTE);
				add_byte(b);
			end
		end
		add_byte(CH_QUOTE);
		for (int i = 0; i < pieces; i++) begin
			if (i == broken_at) begin
				add_broken();
				return;
			end
			add_piece();
		end
		if (broken_at == pieces) begin
			add_broken();
			return;
		end
		add_byte(CH_QUOTE);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic e, input bit typed, input kind_t k,
			input cause_t cz);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		source_ends <= e;
		do @(posedge clk); while (in_stall);
		decode_step(b, e, typed, k, cz);
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(negedge clk) begin
		if (!calm && stall_run == 0 && $urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 19);
		if (calm) stall_run = 0;
		out_stall <= (stall_run > 0);
		if (stall_run > 0) stall_run--;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: kind %0d, byte %0d, cause %0d",
					result_kind, out_byte, error_cause);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("out_byte", want.data, out_byte);
				check_field("error_cause", want.cause, error_cause);
				check_field("decoded_length", want.len, decoded_length);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int sent;
		bit paused;
		drill = '{
			'{8'h61, 1'b0, 1'b1, KIND_REJECT, CAUSE_NO_QUOTE},
			'{8'h00, 1'b1, 1'b1, KIND_REJECT, CAUSE_NO_QUOTE},
			'{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h00, 1'b0, 1'b1, KIND_REJECT, CAUSE_CONTROL},
			'{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h71, 1'b0, 1'b1, KIND_REJECT, CAUSE_BAD_ESCAPE},
			'{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'hff, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_SLASH, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_QUOTE, 1'b0, 1'b1, KIND_REJECT, CAUSE_BAD_UTF8},
			'{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_U, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h44, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h38, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h33, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h64, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_U, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h44, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h45, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h30, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'h30, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, CAUSE_NONE},
			'{8'hff, 1'b1, 1'b1, KIND_REJECT, CAUSE_SOURCE_ENDED}
		};
		limits = '{LEN_W'(0), LEN_W'(3), LEN_W'(16), LEN_W'(262144), LEN_W'(19'h7ffff),
			LEN_W'(4096)};
		open_string();
		scan = M_WAIT;
		max_bytes_reg = MAX_BYTES_RESET;
		paused = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (drill[i]) send_byte(drill[i].b, drill[i].e, drill[i].typed, drill[i].k, drill[i].c);

		foreach (limits[p]) begin
			drain();
			@(negedge clk);
			cfg_write_en <= 1'b1;
			cfg_write_data <= limits[p];
			@(negedge clk) cfg_write_en <= 1'b0;
			max_bytes_reg = limits[p];
			calm = (p == $size(limits) - 1);
			sent = 0;
			while (sent < 60) begin
				// Hold the input once until the output side has caught up completely.
				if (p == 2 && sent >= 30 && !paused) begin
					paused = 1'b1;
					drain();
				end
				script.delete();
				compose_string();
				foreach (script[i]) send_byte(script[i].b, script[i].e, 1'b0, KIND_BYTE, CAUSE_NONE);
				sent += script.size();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
